[hw/rtl/catlru_pkg.sv]
`default_nettype none
package catlru_pkg;

	localparam int TABLE_ENTRIES     = 256;
	localparam int IDX_W             = $clog2(TABLE_ENTRIES);
	localparam int USED_W            = IDX_W + 1;
	localparam int CNT_W             = 32;
	localparam int TIME_W            = 32;
	localparam int KEY_W             = 128;
	localparam int AGE_SCAN_LIMIT    = 2;
	localparam int FORCE_EVICT_LIMIT = 10;
	localparam int AGE_CNT_W         = $clog2(AGE_SCAN_LIMIT + 1);
	localparam int FRC_CNT_W         = $clog2(FORCE_EVICT_LIMIT + 1);
	localparam int PCT_W             = 7;
	localparam int DIV_W             = CNT_W + PCT_W;
	localparam int DATA_W            = TIME_W + 2 * CNT_W;
	localparam int EVICT_W           = 4;
	localparam int SB_W              = 16;
	localparam int SC_W              = 31;

	localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
	localparam logic [SB_W-1:0]  SB_RESET  = SB_W'(50);
	localparam logic [SC_W-1:0]  SC_RESET  = SC_W'(5000);

	typedef enum logic [0:0] {
		REG_SAMPLE_BASE  = 1'b0,
		REG_SAMPLE_CYCLE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_SKIPPED = 2'd0,
		ST_UPDATED = 2'd1,
		ST_CREATED = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

endpackage
`default_nettype wire

[hw/rtl/catlru_ram.sv]
`default_nettype none
module catlru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/catlru_div.sv]
`default_nettype none
module catlru_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [catlru_pkg::DIV_W-1:0] dividend,
	input  wire logic [catlru_pkg::CNT_W-1:0] divisor,
	output logic                             done,
	output logic      [catlru_pkg::PCT_W-1:0] quot
);
	import catlru_pkg::*;

	localparam int STEP_W = $clog2(PCT_W);

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [PCT_W-1:0]  q_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic              ge;

	assign ge   = rem_q >= dvs_q;
	assign done = done_q;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(PCT_W - 1);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= {1'b0, divisor, (PCT_W-1)'(0)};
			q_q   <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			q_q   <= {q_q[PCT_W-2:0], ge};
			dvs_q <= dvs_q >> 1;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/client_activity_table_lru_aging_top.sv]
// Skipped request: result strobe in the cycle after start, busy never rises.
// Tracked request: busy until the result strobe; its length is set by aging, the
// key scan at one slot per cycle up to a hit, forced eviction and the divide.
// One request at a time; busy falls in the cycle of the result strobe.
// Reset clears the valid bits, list pointers and fill count at once; no sweep.
// The receiver cannot stall: each result strobe stands for exactly one cycle.
`default_nettype none
module client_activity_table_lru_aging_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [catlru_pkg::SC_W-1:0]  cfg_wdata,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        track_enable,
	input  wire logic [63:0]                 addr_hi,
	input  wire logic [63:0]                 addr_lo,
	input  wire logic [31:0]                 now_ms,
	input  wire logic                        count_mode,
	input  wire logic                        is_sensitive,
	output logic                             done,
	output logic      [1:0]                  status,
	output logic                             percent_valid,
	output logic      [catlru_pkg::PCT_W-1:0] insens_pct,
	output logic      [catlru_pkg::PCT_W-1:0] badresp_pct,
	output logic      [catlru_pkg::EVICT_W-1:0] evicted_count
);
	import catlru_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE     = 19'h00001,
		S_AGE_RD   = 19'h00002,
		S_AGE_WAIT = 19'h00004,
		S_AGE_DIFF = 19'h00008,
		S_AGE_CMP  = 19'h00010,
		S_SCAN     = 19'h00020,
		S_HIT_WAIT = 19'h00040,
		S_HIT_DIFF = 19'h00080,
		S_HIT_CMP  = 19'h00100,
		S_RM_LINK  = 19'h00200,
		S_PUSH_A   = 19'h00400,
		S_PUSH_B   = 19'h00800,
		S_UPD      = 19'h01000,
		S_PCT      = 19'h02000,
		S_DIV      = 19'h04000,
		S_FRC      = 19'h08000,
		S_FRC_W    = 19'h10000,
		S_NEW      = 19'h20000,
		S_DONE     = 19'h40000
	} state_t;

	state_t state_q, ret_q;

	logic [SB_W-1:0]      base_q;
	logic [SC_W-1:0]      cycle_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]     head_q, tail_q;
	logic [USED_W-1:0]    used_q;

	logic [63:0]          hi_q, lo_q;
	logic [TIME_W-1:0]    now_q;
	logic                 mode_q, sens_q;

	logic [IDX_W-1:0]     rm_idx_q, push_idx_q, cmp_idx_q, free_q, min_q;
	logic [IDX_W:0]       scan_q;
	logic                 cmp_v_q, free_found_q, is_hit_q, exp_q;
	logic [AGE_CNT_W-1:0] agecnt_q;
	logic [FRC_CNT_W-1:0] fcnt_q;
	logic [TIME_W-1:0]    diff_q;
	logic [CNT_W-1:0]     tot_q, ins_q;

	logic                 done_q, pv_q;
	status_t              status_q;
	logic [PCT_W-1:0]     pct_q;
	logic [EVICT_W-1:0]   ev_q;

	logic                 key_we, data_we, prev_we, next_we;
	logic [IDX_W-1:0]     key_waddr, data_waddr, prev_waddr, next_waddr;
	logic [KEY_W-1:0]     key_wdata, key_rd;
	logic [DATA_W-1:0]    data_wdata, data_rd;
	logic [IDX_W-1:0]     prev_wdata, next_wdata, prev_rd, next_rd;

	logic [TIME_W-1:0]    adiff;
	logic                 expired;
	logic [CNT_W-1:0]     t0, i0, t1, i1;
	logic [IDX_W-1:0]     new_slot;
	logic                 div_start, div_done;
	logic [PCT_W-1:0]     div_quot;
	logic [DIV_W-1:0]     prod;
	logic [EVICT_W-1:0]   ev_inc;

	assign adiff   = diff_q[TIME_W-1] ? (~diff_q + 1'b1) : diff_q;
	assign expired = adiff >= {1'b0, cycle_q};
	assign t0      = exp_q ? '0 : tot_q;
	assign i0      = exp_q ? '0 : ins_q;
	assign t1      = t0 + 1'b1;
	assign i1      = (t1 == '0) ? '0 : i0 + CNT_W'(!mode_q && !sens_q);
	assign new_slot = free_found_q ? free_q : min_q;
	assign prod    = {1'b0, ins_q, 6'b0} + {2'b0, ins_q, 5'b0} + {5'b0, ins_q, 2'b0};
	assign ev_inc  = (ev_q == '1) ? ev_q : ev_q + 1'b1;
	assign div_start = (state_q == S_PCT) && (tot_q != '0) && (tot_q >= CNT_W'(base_q))
		&& (ins_q < tot_q);

	assign busy                 = (state_q != S_IDLE);
	assign done                 = done_q;
	assign status               = status_q;
	assign percent_valid        = pv_q;
	assign insens_pct           = pct_q;
	assign badresp_pct          = '0;
	assign evicted_count        = ev_q;

	always_comb begin
		key_we     = 1'b0;
		key_waddr  = new_slot;
		key_wdata  = {hi_q, lo_q};
		data_we    = 1'b0;
		data_waddr = push_idx_q;
		data_wdata = {now_q, t1, i1};
		prev_we    = 1'b0;
		prev_waddr = push_idx_q;
		prev_wdata = push_idx_q;
		next_we    = 1'b0;
		next_waddr = push_idx_q;
		next_wdata = head_q;
		case (state_q)
			S_RM_LINK: begin
				next_we    = (head_q != rm_idx_q);
				next_waddr = prev_rd;
				next_wdata = next_rd;
				prev_we    = (tail_q != rm_idx_q);
				prev_waddr = next_rd;
				prev_wdata = prev_rd;
			end
			S_PUSH_A: begin
				prev_we = 1'b1;
				next_we = 1'b1;
			end
			S_PUSH_B: begin
				prev_we    = (used_q != '0);
				prev_waddr = head_q;
			end
			S_UPD: begin
				data_we = 1'b1;
			end
			S_NEW: begin
				key_we     = 1'b1;
				data_we    = 1'b1;
				data_waddr = new_slot;
				data_wdata = {now_q, CNT_W'(1), CNT_W'(!sens_q)};
			end
			default: begin
			end
		endcase
	end

	catlru_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.raddr(scan_q[IDX_W-1:0]), .rdata(key_rd)
	);

	catlru_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_ENTRIES)) u_data_ram (
		.clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
		.raddr(rm_idx_q), .rdata(data_rd)
	);

	catlru_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(rm_idx_q), .rdata(prev_rd)
	);

	catlru_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(rm_idx_q), .rdata(next_rd)
	);

	catlru_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(prod), .divisor(tot_q), .done(div_done), .quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			base_q   <= SB_RESET;
			cycle_q  <= SC_RESET;
			valid_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			used_q   <= '0;
			done_q   <= 1'b0;
			status_q <= ST_SKIPPED;
			pv_q     <= 1'b0;
			pct_q    <= '0;
			ev_q     <= '0;
			cmp_v_q  <= 1'b0;
			free_found_q <= 1'b0;
			is_hit_q <= 1'b0;
			agecnt_q <= '0;
			fcnt_q   <= '0;
			scan_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SAMPLE_BASE:  base_q  <= cfg_wdata[SB_W-1:0];
					REG_SAMPLE_CYCLE: cycle_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= ST_SKIPPED;
						pv_q     <= 1'b0;
						pct_q    <= '0;
						ev_q     <= '0;
						agecnt_q <= '0;
						is_hit_q <= 1'b0;
						if (track_enable) begin
							state_q <= S_AGE_RD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_AGE_RD: begin
					if (agecnt_q < AGE_CNT_W'(AGE_SCAN_LIMIT) && used_q != '0) begin
						rm_idx_q <= tail_q;
						state_q  <= S_AGE_WAIT;
					end else begin
						scan_q       <= '0;
						cmp_v_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_AGE_WAIT: state_q <= S_AGE_DIFF;
				S_AGE_DIFF: begin
					diff_q  <= now_q - data_rd[DATA_W-1 -: TIME_W];
					state_q <= S_AGE_CMP;
				end
				S_AGE_CMP: begin
					if (expired) begin
						agecnt_q <= agecnt_q + 1'b1;
						ev_q     <= ev_inc;
						ret_q    <= S_AGE_RD;
						state_q  <= S_RM_LINK;
					end else begin
						scan_q       <= '0;
						cmp_v_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					scan_q    <= scan_q + 1'b1;
					cmp_v_q   <= !scan_q[IDX_W];
					cmp_idx_q <= scan_q[IDX_W-1:0];
					if (cmp_v_q) begin
						if (valid_q[cmp_idx_q] && key_rd == {hi_q, lo_q}) begin
							rm_idx_q   <= cmp_idx_q;
							push_idx_q <= cmp_idx_q;
							is_hit_q   <= 1'b1;
							status_q   <= ST_UPDATED;
							ret_q      <= S_PUSH_A;
							state_q    <= S_HIT_WAIT;
						end else begin
							if (!valid_q[cmp_idx_q] && !free_found_q) begin
								free_q       <= cmp_idx_q;
								free_found_q <= 1'b1;
							end
							if (cmp_idx_q == '1) begin
								status_q <= ST_CREATED;
								min_q    <= '1;
								fcnt_q   <= '0;
								state_q  <= (used_q == USED_W'(TABLE_ENTRIES)) ? S_FRC : S_NEW;
							end
						end
					end
				end
				S_HIT_WAIT: state_q <= S_HIT_DIFF;
				S_HIT_DIFF: begin
					diff_q  <= now_q - data_rd[DATA_W-1 -: TIME_W];
					tot_q   <= data_rd[2*CNT_W-1 -: CNT_W];
					ins_q   <= data_rd[CNT_W-1:0];
					state_q <= S_HIT_CMP;
				end
				S_HIT_CMP: begin
					exp_q   <= expired;
					state_q <= S_RM_LINK;
				end
				S_RM_LINK: begin
					if (head_q == rm_idx_q) begin
						head_q <= next_rd;
					end
					if (tail_q == rm_idx_q) begin
						tail_q <= prev_rd;
					end
					valid_q[rm_idx_q] <= 1'b0;
					used_q  <= used_q - 1'b1;
					state_q <= ret_q;
				end
				S_PUSH_A: begin
					if (used_q == '0) begin
						tail_q <= push_idx_q;
					end
					state_q <= S_PUSH_B;
				end
				S_PUSH_B: begin
					head_q <= push_idx_q;
					valid_q[push_idx_q] <= 1'b1;
					used_q  <= used_q + 1'b1;
					state_q <= is_hit_q ? S_UPD : S_DONE;
				end
				S_UPD: begin
					tot_q   <= t1;
					ins_q   <= i1;
					state_q <= S_PCT;
				end
				S_PCT: begin
					if (tot_q != '0 && tot_q >= CNT_W'(base_q)) begin
						pv_q <= 1'b1;
						if (ins_q >= tot_q) begin
							pct_q   <= PCT_FULL;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						pct_q   <= (div_quot > PCT_FULL) ? PCT_FULL : div_quot;
						state_q <= S_DONE;
					end
				end
				S_FRC: begin
					if (fcnt_q < FRC_CNT_W'(FORCE_EVICT_LIMIT) && used_q != '0) begin
						rm_idx_q <= tail_q;
						if (tail_q < min_q) begin
							min_q <= tail_q;
						end
						fcnt_q  <= fcnt_q + 1'b1;
						ev_q    <= ev_inc;
						ret_q   <= S_FRC;
						state_q <= S_FRC_W;
					end else begin
						state_q <= S_NEW;
					end
				end
				S_FRC_W: state_q <= S_RM_LINK;
				S_NEW: begin
					push_idx_q <= new_slot;
					state_q    <= S_PUSH_A;
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			hi_q   <= addr_hi;
			lo_q   <= addr_lo;
			now_q  <= now_ms;
			mode_q <= count_mode;
			sens_q <= is_sensitive;
		end
	end

endmodule
`default_nettype wire

[dv/client_activity_table_lru_aging_top_tb.sv]
`timescale 1ns / 100ps
module client_activity_table_lru_aging_top_tb;
	import catlru_pkg::*;

	typedef struct {
		bit         is_cfg;
		cfg_reg_t   reg_idx;
		bit [30:0]  reg_val;
		bit         te;
		bit [63:0]  hi;
		bit [63:0]  lo;
		bit [31:0]  now;
		bit         mode;
		bit         sens;
	} op_t;

	typedef struct {
		status_t    st;
		bit         pv;
		bit [6:0]   ip;
		bit [6:0]   bp;
		bit [3:0]   ev;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [30:0] cfg_wdata = '0;
	logic        start = 1'b0;
	logic        track_enable = 1'b0;
	logic [63:0] addr_hi = '0;
	logic [63:0] addr_lo = '0;
	logic [31:0] now_ms = '0;
	logic        count_mode = 1'b0;
	logic        is_sensitive = 1'b0;
	logic        busy, done, percent_valid;
	logic [1:0]  status;
	logic [6:0]  insens_pct, badresp_pct;
	logic [3:0]  evicted_count;

	client_activity_table_lru_aging_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .start(start), .busy(busy),
		.track_enable(track_enable), .addr_hi(addr_hi), .addr_lo(addr_lo),
		.now_ms(now_ms), .count_mode(count_mode), .is_sensitive(is_sensitive),
		.done(done), .status(status), .percent_valid(percent_valid),
		.insens_pct(insens_pct),
		.badresp_pct(badresp_pct), .evicted_count(evicted_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// client table mirror
	bit [15:0] m_base;
	bit [30:0] m_cycle;
	bit        t_valid [TABLE_ENTRIES];
	bit [63:0] t_hi [TABLE_ENTRIES];
	bit [63:0] t_lo [TABLE_ENTRIES];
	bit [31:0] t_seen [TABLE_ENTRIES];
	bit [31:0] t_total [TABLE_ENTRIES];
	bit [31:0] t_insens [TABLE_ENTRIES];
	int        t_prev [TABLE_ENTRIES];
	int        t_next [TABLE_ENTRIES];
	int        mru, lru, n_used;

	op_t  pending_ops[$];
	res_t results_due[$];
	op_t  cur;
	int   errors = 0;
	int   gap = 0;
	int   quiet = 0;
	bit   no_idle = 1'b0;
	bit [31:0] tnow = 0;

	function automatic bit [31:0] idle_ms(bit [31:0] seen, bit [31:0] now);
		bit [31:0] d;
		d = now - seen;
		if (d[31])
			d = -d;
		return d;
	endfunction

	function automatic void unlink(int i);
		int p, n;
		p = t_prev[i];
		n = t_next[i];
		if (mru == i) mru = n; else t_next[p] = n;
		if (lru == i) lru = p; else t_prev[n] = p;
		t_valid[i] = 1'b0;
		n_used--;
	endfunction

	function automatic void to_front(int i);
		t_prev[i] = i;
		t_next[i] = mru;
		if (n_used == 0) lru = i; else t_prev[mru] = i;
		mru = i;
		t_valid[i] = 1'b1;
		n_used++;
	endfunction

	function automatic res_t lookup_and_update(op_t r);
		res_t e;
		int hit, k, fr, evc;
		longint unsigned q;
		e = '{ST_SKIPPED, 1'b0, 7'd0, 7'd0, 4'd0};
		hit = -1;
		evc = 0;
		if (!r.te)
			return e;
		for (k = 0; k < AGE_SCAN_LIMIT && n_used != 0; k++) begin
			if (idle_ms(t_seen[lru], r.now) < {1'b0, m_cycle})
				break;
			unlink(lru);
			evc++;
		end
		for (k = 0; k < TABLE_ENTRIES; k++)
			if (hit < 0 && t_valid[k] && t_hi[k] == r.hi && t_lo[k] == r.lo)
				hit = k;
		if (hit >= 0) begin
			if (idle_ms(t_seen[hit], r.now) >= {1'b0, m_cycle}) begin
				t_total[hit] = 0;
				t_insens[hit] = 0;
			end
			unlink(hit);
			to_front(hit);
			t_seen[hit] = r.now;
			if (!r.mode && !r.sens)
				t_insens[hit] = t_insens[hit] + 1;
			t_total[hit] = t_total[hit] + 1;
			if (t_total[hit] == 0)
				t_insens[hit] = 0;
			if (t_total[hit] != 0 && t_total[hit] >= {16'd0, m_base}) begin
				e.pv = 1'b1;
				if (t_insens[hit] >= t_total[hit])
					q = 100;
				else
					q = (longint'(t_insens[hit]) * 100) / t_total[hit];
				e.ip = q[6:0];
			end
			e.st = ST_UPDATED;
		end else begin
			if (n_used >= TABLE_ENTRIES)
				for (k = 0; k < FORCE_EVICT_LIMIT && n_used != 0; k++) begin
					unlink(lru);
					evc++;
				end
			fr = -1;
			for (k = 0; k < TABLE_ENTRIES; k++)
				if (fr < 0 && !t_valid[k])
					fr = k;
			if (fr >= 0) begin
				t_hi[fr] = r.hi;
				t_lo[fr] = r.lo;
				t_seen[fr] = r.now;
				t_total[fr] = 1;
				t_insens[fr] = r.sens ? 0 : 1;
				to_front(fr);
			end
			e.st = ST_CREATED;
		end
		e.ev = evc > 15 ? 4'd15 : evc[3:0];
		return e;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit go, we;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			go = start;
			we = 1'b0;
			if (start && !busy) begin
				results_due.push_back(lookup_and_update(cur));
				go = 1'b0;
				if (!no_idle && $urandom_range(0, 3) == 0)
					gap = $urandom_range(1, 11);
			end
			quiet = results_due.size() == 0 ? quiet + 1 : 0;
			if (!go) begin
				if (gap > 0)
					gap--;
				else if (pending_ops.size() > 0) begin
					if (pending_ops[0].is_cfg) begin
						if (quiet >= 8 && !busy) begin
							we = 1'b1;
							cfg_index <= pending_ops[0].reg_idx;
							cfg_wdata <= pending_ops[0].reg_val;
							if (pending_ops[0].reg_idx == REG_SAMPLE_BASE)
								m_base = pending_ops[0].reg_val[15:0];
							else
								m_cycle = pending_ops[0].reg_val;
							void'(pending_ops.pop_front());
						end
					end else begin
						cur = pending_ops.pop_front();
						go = 1'b1;
						track_enable <= cur.te;
						addr_hi <= cur.hi;
						addr_lo <= cur.lo;
						now_ms <= cur.now;
						count_mode <= cur.mode;
						is_sensitive <= cur.sens;
					end
				end
			end
			start <= go;
			cfg_we <= we;
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, status);
				errors++;
			end else begin
				e = results_due.pop_front();
				check_field("status", e.st, status);
				check_field("percent_valid", e.pv, percent_valid);
				check_field("insens_pct", e.ip, insens_pct);
				check_field("badresp_pct", e.bp, badresp_pct);
				check_field("evicted_count", e.ev, evicted_count);
			end
		end
	end

	task automatic add_cfg(cfg_reg_t idx, bit [30:0] val);
		op_t o;
		o = '{1'b1, idx, val, 1'b0, 64'd0, 64'd0, 32'd0, 1'b0, 1'b0};
		pending_ops.push_back(o);
	endtask

	task automatic add_req(bit te, bit [63:0] hi, bit [63:0] lo, bit [31:0] now,
			bit mode, bit sens);
		op_t o;
		o = '{1'b0, REG_SAMPLE_BASE, 31'd0, te, hi, lo, now, mode, sens};
		pending_ops.push_back(o);
	endtask

	function automatic bit [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit [31:0] step_time();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return $urandom;
		else if (r < 3)
			return $urandom_range(1000, 20000);
		return $urandom_range(0, 300);
	endfunction

	initial begin
		bit [63:0] pool_hi [16];
		bit [63:0] pool_lo [16];
		int ph, n, k, j;
		m_base = 50;
		m_cycle = 5000;
		mru = 0;
		lru = 0;
		n_used = 0;
		foreach (t_valid[i])
			t_valid[i] = 1'b0;

		add_req(1'b0, '1, '1, '1, 1'b1, 1'b1);
		add_req(1'b1, 64'd0, 64'd0, 32'd0, 1'b0, 1'b0);
		add_req(1'b1, '1, '1, 32'd10, 1'b1, 1'b1);
		add_req(1'b1, 64'd0, 64'd0, 32'd20, 1'b0, 1'b0);
		add_cfg(REG_SAMPLE_BASE, 31'd1);
		add_cfg(REG_SAMPLE_CYCLE, 31'h7FFF_FFFF);
		add_req(1'b1, 64'd0, 64'd0, 32'd30, 1'b0, 1'b1);
		add_req(1'b1, 64'd0, 64'd0, 32'd40, 1'b1, 1'b0);
		add_req(1'b1, '1, '1, 32'hFFFF_FFFF, 1'b0, 1'b0);
		add_req(1'b1, '1, '1, 32'h8000_0000, 1'b0, 1'b1);
		add_req(1'b1, 64'd0, 64'd1, 32'h8000_0001, 1'b0, 1'b0);
		// three fresh entries, then a hit on an expired one after two age out
		add_cfg(REG_SAMPLE_CYCLE, 31'd100);
		add_req(1'b1, 64'd5, 64'd5, 32'd1000, 1'b0, 1'b0);
		add_req(1'b1, 64'd6, 64'd6, 32'd1000, 1'b0, 1'b0);
		add_req(1'b1, 64'd7, 64'd7, 32'd1000, 1'b0, 1'b1);
		add_req(1'b1, 64'd7, 64'd7, 32'd1200, 1'b0, 1'b0);
		add_req(1'b1, 64'd7, 64'd7, 32'd1299, 1'b0, 1'b0);
		add_cfg(REG_SAMPLE_CYCLE, 31'd1);
		add_req(1'b1, 64'd8, 64'd8, 32'd1300, 1'b0, 1'b0);
		add_req(1'b1, 64'd8, 64'd8, 32'd1300, 1'b0, 1'b0);
		add_cfg(REG_SAMPLE_BASE, 31'd65535);
		add_req(1'b1, 64'd8, 64'd8, 32'd1300, 1'b0, 1'b0);
		tnow = 2000;

		for (ph = 0; ph < 7; ph++) begin
			case (ph % 4)
				0: add_cfg(REG_SAMPLE_BASE, 31'($urandom_range(1, 4)));
				1: add_cfg(REG_SAMPLE_BASE, 31'($urandom_range(5, 20)));
				2: add_cfg(REG_SAMPLE_BASE, 31'd65535);
				default: add_cfg(REG_SAMPLE_BASE, 31'($urandom_range(1, 65535)));
			endcase
			if (ph == 3) begin
				// fill past capacity to force evictions
				add_cfg(REG_SAMPLE_CYCLE, 31'h7FFF_FFFF);
				for (k = 0; k < 320; k++) begin
					tnow += $urandom_range(0, 5);
					add_req(1'b1, rnd64(), rnd64(), tnow, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					if (k % 40 == 0)
						add_req(1'b1, 64'd0, 64'd0, tnow, 1'b0, 1'b0);
				end
				continue;
			end
			case ($urandom_range(0, 2))
				0: add_cfg(REG_SAMPLE_CYCLE, 31'($urandom_range(50, 5000)));
				1: add_cfg(REG_SAMPLE_CYCLE, 31'($urandom_range(1, 3)));
				default: add_cfg(REG_SAMPLE_CYCLE, 31'($urandom));
			endcase
			for (j = 0; j < 16; j++) begin
				pool_hi[j] = rnd64();
				pool_lo[j] = j < 4 ? pool_lo[0] ^ (64'd1 << $urandom_range(0, 63)) : rnd64();
			end
			n = 268;
			for (k = 0; k < n; k++) begin
				tnow += step_time();
				j = $urandom_range(0, 15);
				if ($urandom_range(0, 9) == 0)
					add_req(1'b0, rnd64(), rnd64(), $urandom, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else if ($urandom_range(0, 9) == 0)
					add_req(1'b1, rnd64(), rnd64(), tnow, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					add_req(1'b1, pool_hi[j], pool_lo[j], tnow, $urandom_range(0, 3) == 0,
						$urandom_range(0, 2) == 0);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_ops.size() < 150);
		no_idle = 1'b1;
		wait (pending_ops.size() == 0 && !start && results_due.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && results_due.size() == 0)
			$display("client_activity_table_lru_aging_top regression: pass");
		else
			$display("client_activity_table_lru_aging_top regression: fail");
		$finish;
	end

	initial begin
		#25000000;
		$display("client_activity_table_lru_aging_top regression: fail");
		$finish;
	end

endmodule

[files.f]
hw/rtl/catlru_pkg.sv
hw/rtl/catlru_ram.sv
hw/rtl/catlru_div.sv
hw/rtl/client_activity_table_lru_aging_top.sv
dv/client_activity_table_lru_aging_top_tb.sv
